@@ sv/ttip_pkg.sv @@
package ttip_pkg;

  localparam int MAX_LEN_DEF = 4096;
  localparam int OFS_W       = 13;
  localparam int REG_IDX_W   = 3;
  localparam int REG_DATA_W  = 7;

  localparam logic [REG_IDX_W-1:0] REG_BASE_SETTING  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RESULT_WIDTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIGNED_RESULT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POW2_UNSIGNED = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SUPPRESS_OVF  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PREFIX_RESCAN = 3'd5;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  localparam logic [7:0] NOT_DIGIT = 8'hFF;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [63:0]      value;
    logic [OFS_W-1:0] stop_offset;
    logic             invalid;
    logic             bad_digit;
    logic             overflow;
    logic             negative;
    logic             consumed;
  } result_t;

  typedef struct packed {
    logic [6:0] base_setting;
    logic [1:0] result_width;
    logic       signed_result;
    logic       pow2_base_unsigned;
    logic       suppress_overflow;
    logic       prefix_rescan;
  } cfg_t;

  typedef enum logic [9:0] {
    PH_WS     = 10'b0000000001,
    PH_SIGN   = 10'b0000000010,
    PH_ZERO   = 10'b0000000100,
    PH_XSEEN  = 10'b0000001000,
    PH_PFX1   = 10'b0000010000,
    PH_PFX2   = 10'b0000100000,
    PH_HASH   = 10'b0001000000,
    PH_DIGITS = 10'b0010000000,
    PH_OVF    = 10'b0100000000,
    PH_DONE   = 10'b1000000000
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [63:0]      acc;
    logic [6:0]       base;
    logic             minus;
    logic             inval;
    logic             ebad;
    logic             over;
    logic [OFS_W-1:0] stop;
  } scan_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] digit_of(input logic [7:0] c, input logic wide);
    logic [7:0] d;
    d = NOT_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + (wide ? 8'd36 : 8'd10);
    end else if (wide && c == CH_AT) begin
      d = 8'd62;
    end else if (wide && c == CH_US) begin
      d = 8'd63;
    end
    return d;
  endfunction

  function automatic logic is_pow2(input logic [6:0] b);
    return (b & (b - 7'd1)) == 7'd0;
  endfunction

endpackage

@@ sv/ttip_step.sv @@
module ttip_step (
  input  ttip_pkg::scan_t             cur,
  input  logic [7:0]                  char_code,
  input  logic [ttip_pkg::OFS_W-1:0]  idx,
  input  logic                        rescan,
  output ttip_pkg::scan_t             nxt
);

  ttip_pkg::scan_t st;
  logic [6:0]  nb;
  logic [7:0]  d3;
  logic        hash_take;
  logic [7:0]  d;
  logic        dv;
  logic        dz;
  logic [70:0] mac;
  logic        is_hash;
  logic        is_dec;
  logic        is_sign;
  logic        is_x;
  logic        is_b;
  logic        zsw;
  logic [6:0]  zb;
  logic        hash_ok;

  always_comb begin
    nb        = cur.acc[6:0];
    d3        = ttip_pkg::digit_of(char_code, nb > 7'd36);
    hash_take = (cur.phase == ttip_pkg::PH_HASH) && ((d3 < {1'b0, nb}) || rescan);

    // accepted B# prefix: new base, restart scan or take this char as first digit
    st = cur;
    if (hash_take) begin
      st.base  = nb;
      st.acc   = '0;
      st.ebad  = 1'b0;
      st.stop  = '0;
      st.phase = rescan ? ttip_pkg::PH_WS : ttip_pkg::PH_DIGITS;
    end

    d   = ttip_pkg::digit_of(char_code, st.base > 7'd36);
    dv  = d < {1'b0, st.base};
    zb  = (st.base == 7'd0) ? 7'd8 : st.base;
    dz  = d < {1'b0, zb};
    mac = 71'(st.acc) * 71'(st.base) + 71'(d);

    is_hash = char_code == ttip_pkg::CH_HASH;
    is_dec  = char_code >= ttip_pkg::CH_0 && char_code <= ttip_pkg::CH_9;
    is_sign = char_code == ttip_pkg::CH_PLUS || char_code == ttip_pkg::CH_MINUS;
    is_x    = char_code == ttip_pkg::CH_LX || char_code == ttip_pkg::CH_UX;
    is_b    = char_code == ttip_pkg::CH_LB || char_code == ttip_pkg::CH_UB;
    zsw     = (is_x && (st.base == 7'd0 || st.base == 7'd16)) ||
              (is_b && (st.base == 7'd0 || st.base == 7'd2));
    hash_ok = is_hash && ((st.phase == ttip_pkg::PH_PFX1) ? (st.acc[6:0] >= 7'd2)
                                                          : (st.acc[6:0] <= 7'd64));

    nxt = st;
    case (st.phase)
      ttip_pkg::PH_WS, ttip_pkg::PH_SIGN: begin
        if (st.phase == ttip_pkg::PH_WS && ttip_pkg::is_ws(char_code)) begin
          nxt.phase = ttip_pkg::PH_WS;
        end else if (st.phase == ttip_pkg::PH_WS && is_sign) begin
          nxt.minus = st.minus | (char_code == ttip_pkg::CH_MINUS);
          nxt.phase = ttip_pkg::PH_SIGN;
        end else if (char_code == ttip_pkg::CH_0) begin
          nxt.phase = ttip_pkg::PH_ZERO;
        end else if (st.base == 7'd0) begin
          nxt.base = 7'd10;
          if (is_dec) begin
            nxt.acc   = 64'(d);
            nxt.phase = ttip_pkg::PH_PFX1;
          end else begin
            nxt.inval = 1'b1;
            nxt.stop  = idx;
            nxt.phase = ttip_pkg::PH_DONE;
          end
        end else if (dv) begin
          nxt.acc   = 64'(d);
          nxt.phase = ttip_pkg::PH_DIGITS;
        end else begin
          nxt.inval = 1'b1;
          nxt.stop  = idx;
          nxt.phase = ttip_pkg::PH_DONE;
        end
      end
      ttip_pkg::PH_ZERO: begin
        if (zsw) begin
          nxt.base  = is_x ? 7'd16 : 7'd2;
          nxt.acc   = '0;
          nxt.stop  = idx;
          nxt.ebad  = 1'b1;
          nxt.phase = ttip_pkg::PH_XSEEN;
        end else begin
          nxt.base = zb;
          if (dz) begin
            nxt.acc   = 64'(d);
            nxt.phase = ttip_pkg::PH_DIGITS;
          end else begin
            nxt.stop  = idx;
            nxt.ebad  = !ttip_pkg::is_ws(char_code);
            nxt.phase = ttip_pkg::PH_DONE;
          end
        end
      end
      ttip_pkg::PH_XSEEN: begin
        if (dv) begin
          nxt.acc   = 64'(d);
          nxt.ebad  = 1'b0;
          nxt.phase = ttip_pkg::PH_DIGITS;
        end else begin
          nxt.phase = ttip_pkg::PH_DONE;
        end
      end
      ttip_pkg::PH_PFX1, ttip_pkg::PH_PFX2, ttip_pkg::PH_DIGITS: begin
        if (st.phase != ttip_pkg::PH_DIGITS && hash_ok) begin
          nxt.stop  = idx;
          nxt.ebad  = 1'b1;
          nxt.phase = ttip_pkg::PH_HASH;
        end else if (dv) begin
          if (|mac[70:64]) begin
            nxt.phase = ttip_pkg::PH_OVF;
          end else begin
            nxt.acc   = mac[63:0];
            nxt.phase = (st.phase == ttip_pkg::PH_PFX1) ? ttip_pkg::PH_PFX2
                                                        : ttip_pkg::PH_DIGITS;
          end
        end else begin
          nxt.stop  = idx;
          nxt.ebad  = !ttip_pkg::is_ws(char_code);
          nxt.phase = ttip_pkg::PH_DONE;
        end
      end
      ttip_pkg::PH_HASH: begin
        // prefix rejected: stop at the '#' as decimal
        nxt.phase = ttip_pkg::PH_DONE;
      end
      ttip_pkg::PH_OVF: begin
        if (!dv) begin
          nxt.over  = 1'b1;
          nxt.stop  = idx;
          nxt.phase = ttip_pkg::PH_DONE;
        end
      end
      ttip_pkg::PH_DONE: begin
        nxt.phase = ttip_pkg::PH_DONE;
      end
      default: begin
        nxt = st;
      end
    endcase
  end

endmodule

@@ sv/ttip_finish.sv @@
module ttip_finish (
  input  ttip_pkg::scan_t             snap,
  input  logic [ttip_pkg::OFS_W-1:0]  len,
  input  ttip_pkg::cfg_t              cfg,
  output ttip_pkg::result_t           res_out
);

  logic                       inval;
  logic                       ebad;
  logic                       over;
  logic                       minus;
  logic [6:0]                 base;
  logic [63:0]                res;
  logic [ttip_pkg::OFS_W-1:0] p;
  logic                       cons;
  logic [63:0]                wm;
  logic [63:0]                um;
  logic                       bad_base;

  always_comb begin
    inval = 1'b0;
    ebad  = 1'b0;
    over  = 1'b0;
    minus = snap.minus;
    base  = snap.base;
    res   = snap.acc;
    p     = snap.stop;
    cons  = 1'b0;

    case (snap.phase)
      ttip_pkg::PH_WS, ttip_pkg::PH_SIGN: begin
        inval = 1'b1;
        p     = len;
        cons  = 1'b1;
      end
      ttip_pkg::PH_ZERO, ttip_pkg::PH_PFX1, ttip_pkg::PH_PFX2, ttip_pkg::PH_DIGITS: begin
        p    = len;
        cons = 1'b1;
      end
      ttip_pkg::PH_OVF: begin
        over = 1'b1;
        p    = len;
        cons = 1'b1;
      end
      ttip_pkg::PH_HASH: begin
        if (cfg.prefix_rescan) begin
          inval = 1'b1;
          base  = snap.acc[6:0];
          p     = len;
          cons  = 1'b1;
        end else begin
          ebad = snap.ebad;
        end
      end
      default: begin
        inval = snap.inval;
        ebad  = snap.ebad;
        over  = snap.over;
      end
    endcase

    bad_base = cfg.base_setting == 7'd1 || cfg.base_setting > 7'd64;
    if (bad_base) begin
      inval = 1'b1;
      ebad  = 1'b0;
      over  = 1'b0;
      minus = 1'b0;
      base  = cfg.base_setting;
      p     = '0;
      cons  = len == '0;
    end

    if (inval || over) begin
      if (cfg.signed_result) begin
        res = minus ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        res   = '1;
        minus = 1'b0;
      end
    end

    case (cfg.result_width)
      ttip_pkg::WIDTH_8:  wm = 64'h0000_0000_0000_00FF;
      ttip_pkg::WIDTH_16: wm = 64'h0000_0000_0000_FFFF;
      ttip_pkg::WIDTH_32: wm = 64'h0000_0000_FFFF_FFFF;
      default:            wm = '1;
    endcase
    um = wm;
    if (cfg.signed_result && (!cfg.pow2_base_unsigned || !ttip_pkg::is_pow2(base))) begin
      um = wm >> 1;
    end

    if (|(res & ~um)) begin
      if (cfg.signed_result && minus) begin
        if ({1'b0, res} > ({1'b0, um} + 65'd1)) begin
          res  = (um << 1) & ~um;
          over = 1'b1;
        end else begin
          res = 64'd0 - res;
        end
      end else begin
        res  = um;
        over = 1'b1;
      end
    end else if (minus) begin
      res = 64'd0 - res;
    end

    if (cfg.suppress_overflow) begin
      over = 1'b0;
    end

    res_out.value       = res & wm;
    res_out.stop_offset = p;
    res_out.invalid     = inval;
    res_out.bad_digit   = ebad;
    res_out.overflow    = over;
    res_out.negative    = minus;
    res_out.consumed    = cons;
  end

endmodule

@@ sv/text_to_integer_parser.sv @@
// Integer parser for text streams. One character enters per transaction and
// a new one is taken every cycle unless char_stall holds it; a string ends
// on a zero byte or a character marked last. Its scan state is snapshotted,
// then clamped, signed and registered as the result. Each digit costs one
// 64-bit by 7-bit multiply-add in the scan stage. Configuration writes must
// come between strings, with no result pending; the block does not enforce
// this. Characters past MAX_LEN are dropped and the string is parsed as if
// it ended there; stop_offset is the low 13 bits of the stop position.
module text_to_integer_parser #(
  parameter int MAX_LEN = ttip_pkg::MAX_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           char_valid,
  output logic                           char_stall,
  input  ttip_pkg::char_item_t           char_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output ttip_pkg::result_t              result_data,
  input  logic                           wr_en,
  input  logic [ttip_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [ttip_pkg::REG_DATA_W-1:0] wr_data
);

  localparam int PW = $clog2(MAX_LEN + 1);

  ttip_pkg::cfg_t             cfg;
  logic [PW-1:0]              pos;
  ttip_pkg::scan_t            state;
  ttip_pkg::scan_t            init;
  ttip_pkg::scan_t            cur;
  ttip_pkg::scan_t            stepped;
  ttip_pkg::scan_t            state_next;
  ttip_pkg::scan_t            snap;
  logic [ttip_pkg::OFS_W-1:0] snap_len;
  logic                       snap_valid;
  logic                       snap_move;
  logic                       accept;
  logic                       store;
  logic                       end_str;
  logic [PW-1:0]              pos_next;
  ttip_pkg::result_t          fin;

  always_comb begin
    init       = '0;
    init.phase = ttip_pkg::PH_WS;
    init.base  = cfg.base_setting;
    cur        = (pos == '0) ? init : state;
  end

  ttip_step u_step (
    .cur       (cur),
    .char_code (char_data.char_code),
    .idx       (ttip_pkg::OFS_W'(pos)),
    .rescan    (cfg.prefix_rescan),
    .nxt       (stepped)
  );

  assign snap_move  = snap_valid && (!result_valid || !result_stall);
  assign char_stall = snap_valid && result_valid && result_stall;
  assign accept     = char_valid && !char_stall;
  assign store      = (char_data.char_code != 8'd0) && (pos < PW'(MAX_LEN));
  assign end_str    = (char_data.char_code == 8'd0) || char_data.last;
  assign state_next = store ? stepped : cur;
  assign pos_next   = pos + PW'(store);

  ttip_finish u_finish (
    .snap    (snap),
    .len     (snap_len),
    .cfg     (cfg),
    .res_out (fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_setting       <= 7'd0;
      cfg.result_width       <= ttip_pkg::WIDTH_64;
      cfg.signed_result      <= 1'b0;
      cfg.pow2_base_unsigned <= 1'b0;
      cfg.suppress_overflow  <= 1'b0;
      cfg.prefix_rescan      <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        ttip_pkg::REG_BASE_SETTING:  cfg.base_setting       <= wr_data[6:0];
        ttip_pkg::REG_RESULT_WIDTH:  cfg.result_width       <= wr_data[1:0];
        ttip_pkg::REG_SIGNED_RESULT: cfg.signed_result      <= wr_data[0];
        ttip_pkg::REG_POW2_UNSIGNED: cfg.pow2_base_unsigned <= wr_data[0];
        ttip_pkg::REG_SUPPRESS_OVF:  cfg.suppress_overflow  <= wr_data[0];
        ttip_pkg::REG_PREFIX_RESCAN: cfg.prefix_rescan      <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      snap_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= end_str ? '0 : pos_next;
      end
      if (accept && end_str) begin
        snap_valid <= 1'b1;
      end else if (snap_move) begin
        snap_valid <= 1'b0;
      end
      if (snap_move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      state <= state_next;
    end
    if (accept && end_str) begin
      snap     <= state_next;
      snap_len <= ttip_pkg::OFS_W'(pos_next);
    end
    if (snap_move) begin
      result_data <= fin;
    end
  end

endmodule

@@ test/ttip_checker.sv @@
module ttip_checker
  import ttip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  input  logic                 char_stall,
  input  char_item_t           char_data,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result_data,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [REG_DATA_W-1:0] wr_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_LEN = 4096;
  localparam int GO_ON   = 0;
  localparam int AT_END  = 1;
  localparam int AT_BAD  = 2;
  localparam int AT_OVER = 3;
  localparam int AT_INV  = 4;

  cfg_t        cfg;
  logic [7:0]  text [BUF_LEN];
  int unsigned text_len;
  result_t     awaited [$];

  function automatic bit is_blank(int unsigned c);
    return c == 32 || (c >= 9 && c <= 13);
  endfunction

  function automatic int unsigned glyph_value(int unsigned c, bit wide);
    if (c >= 48 && c <= 57) return c - 48;
    if (c >= 97 && c <= 122) return c - 97 + 10;
    if (c >= 65 && c <= 90) return c - 65 + (wide ? 36 : 10);
    if (wide && c == 64) return 62;
    if (wide && c == 95) return 63;
    return 255;
  endfunction

  function automatic int unsigned char_at(int unsigned i, int unsigned n);
    return (i < n) ? int'(text[i]) : 0;
  endfunction

  // digit test shared by the prefix and digit loops: 1 when c is no digit in b
  function automatic bit not_digit(int unsigned c, bit wide, int unsigned b);
    return (c >= 128) || glyph_value(c, wide) >= b;
  endfunction

  function automatic result_t predict_number(int unsigned n);
    int unsigned p, b, c, d, nb, c1, c2, c3;
    bit wide, minus, inval, ebad, over, again, hex;
    int st;
    longint unsigned acc, cut, wm, um;
    result_t r;
    p = 0; b = cfg.base_setting; d = 0; wide = b > 36;
    minus = 0; inval = 0; ebad = 0; over = 0; acc = 0; st = GO_ON;
    if (n == 0 || b == 1 || b > 64) begin
      st = AT_INV;
    end else begin
      again = 1;
      while (again && st == GO_ON) begin
        again = 0;
        while (st == GO_ON && is_blank(char_at(p, n))) begin
          p++;
          if (p >= n) st = AT_INV;
        end
        if (st == GO_ON) begin
          c = char_at(p, n);
          if (c == 45) minus = 1;
          if (c == 45 || c == 43) begin
            p++;
            if (p >= n) st = AT_INV;
          end
        end
        if (st != GO_ON) break;
        if (char_at(p, n) != 48) begin
          if (b == 0) begin
            b = 10;
            c1 = char_at(p, n);
            c2 = char_at(p + 1, n);
            if (n - p > 1 && c1 >= 48 && c1 <= 57 &&
                (c2 == 35 || (c2 >= 48 && c2 <= 57 && n - p > 2 &&
                              char_at(p + 2, n) == 35))) begin
              nb = c1 - 48;
              if (c2 == 35) begin
                c3 = char_at(p + 2, n);
              end else begin
                c3 = char_at(p + 3, n);
                nb = nb * 10 + (c2 - 48);
              end
              wide = nb > 36;
              if (nb < 2 || nb > 64 || (not_digit(c3, wide, nb) && !cfg.prefix_rescan)) begin
                b = 10;
              end else begin
                b = nb;
                p += (c2 == 35) ? 2 : 3;
                if (cfg.prefix_rescan) again = 1;
              end
            end
          end
          if (!again) begin
            c = char_at(p, n);
            if (not_digit(c, wide, b)) st = AT_INV;
            else d = glyph_value(c, wide);
          end
        end else begin
          p++;
          if (p >= n) begin
            st = AT_END;
          end else begin
            if (b == 0 || b == 2 || b == 16) begin
              c = char_at(p, n);
              if (c == 120 || c == 88 || c == 98 || c == 66) begin
                hex = (c == 120 || c == 88);
                if ((hex && (b & 2) == 0) || (!hex && (b & 16) == 0)) begin
                  b = hex ? 16 : 2;
                  c = char_at(p + 1, n);
                  if (n - p > 1 && !not_digit(c, wide, b)) p++;
                end
              end else if (b == 0) begin
                b = 8;
              end
            end
            c = char_at(p, n);
            if (not_digit(c, wide, b)) st = AT_BAD;
            else d = glyph_value(c, wide);
          end
        end
      end
    end

    if (st == GO_ON) begin
      cut = 64'hFFFF_FFFF_FFFF_FFFF / longint'(b);
      while (st == GO_ON) begin
        if (acc >= cut) begin
          if (acc != cut) begin
            st = AT_OVER;
          end else begin
            acc = acc * b;
            if (acc > 64'hFFFF_FFFF_FFFF_FFFF - d) st = AT_OVER;
            else acc = acc + d;
          end
        end else begin
          acc = acc * b + d;
        end
        if (st == GO_ON) begin
          p++;
          if (p >= n) begin
            st = AT_END;
          end else begin
            c = char_at(p, n);
            if (not_digit(c, wide, b)) st = AT_BAD;
            else d = glyph_value(c, wide);
          end
        end
      end
    end

    if (st == AT_BAD) begin
      c = char_at(p, n);
      if (c != 0 && !is_blank(c)) ebad = 1;
    end else if (st == AT_OVER) begin
      while (1) begin
        p++;
        if (p >= n) break;
        if (not_digit(char_at(p, n), wide, b)) break;
      end
      over = 1;
    end else if (st == AT_INV) begin
      inval = 1;
    end
    if (st == AT_OVER || st == AT_INV) begin
      if (cfg.signed_result) begin
        acc = minus ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        acc = '1;
        minus = 0;
      end
    end

    case (cfg.result_width)
      WIDTH_8:  wm = 64'hFF;
      WIDTH_16: wm = 64'hFFFF;
      WIDTH_32: wm = 64'hFFFF_FFFF;
      default:  wm = '1;
    endcase
    um = wm;
    if (cfg.signed_result && (!cfg.pow2_base_unsigned || (b & (b - 1)) != 0)) um = um >> 1;
    if ((acc & ~um) != 0) begin
      if (cfg.signed_result && minus) begin
        if (acc > um + 1) begin
          acc = (um << 1) & ~um;
          over = 1;
        end else begin
          acc = 0 - acc;
        end
      end else begin
        acc = um;
        over = 1;
      end
    end else if (minus) begin
      acc = 0 - acc;
    end
    if (cfg.suppress_overflow) over = 0;

    r.value       = acc & wm;
    r.stop_offset = p[OFS_W-1:0];
    r.invalid     = inval;
    r.bad_digit   = ebad;
    r.overflow    = over;
    r.negative    = minus;
    r.consumed    = p >= n;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg <= '{base_setting: 7'd0, result_width: WIDTH_64, default: 1'b0};
      text_len = 0;
      errors = 0;
      awaited.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_BASE_SETTING:  cfg.base_setting       <= wr_data;
          REG_RESULT_WIDTH:  cfg.result_width       <= wr_data[1:0];
          REG_SIGNED_RESULT: cfg.signed_result      <= wr_data[0];
          REG_POW2_UNSIGNED: cfg.pow2_base_unsigned <= wr_data[0];
          REG_SUPPRESS_OVF:  cfg.suppress_overflow  <= wr_data[0];
          REG_PREFIX_RESCAN: cfg.prefix_rescan      <= wr_data[0];
          default: ;
        endcase
      end
      if (char_valid && !char_stall) begin
        if (char_data.char_code != 8'd0 && text_len < BUF_LEN) begin
          text[text_len] = char_data.char_code;
          text_len++;
        end
        if (char_data.char_code == 8'd0 || char_data.last) begin
          awaited.push_back(predict_number(text_len));
          text_len = 0;
        end
      end
      if (result_valid && !result_stall) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected transaction", result_data.value, 64'd0);
        end else begin
          want = awaited.pop_front();
          if (result_data.value !== want.value)
            report_mismatch("value", result_data.value, want.value);
          if (result_data.stop_offset !== want.stop_offset)
            report_mismatch("stop_offset", result_data.stop_offset, want.stop_offset);
          if (result_data.invalid !== want.invalid)
            report_mismatch("invalid", result_data.invalid, want.invalid);
          if (result_data.bad_digit !== want.bad_digit)
            report_mismatch("bad_digit", result_data.bad_digit, want.bad_digit);
          if (result_data.overflow !== want.overflow)
            report_mismatch("overflow", result_data.overflow, want.overflow);
          if (result_data.negative !== want.negative)
            report_mismatch("negative", result_data.negative, want.negative);
          if (result_data.consumed !== want.consumed)
            report_mismatch("consumed", result_data.consumed, want.consumed);
        end
      end
    end
    pending = awaited.size();
  end

endmodule

@@ test/tb.sv @@
module tb;
  import ttip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  char_valid = 0;
  logic                  char_stall;
  char_item_t            char_data = '0;
  logic                  result_valid;
  logic                  result_stall = 0;
  result_t               result_data;
  logic                  wr_en = 0;
  logic [REG_IDX_W-1:0]  wr_index = '0;
  logic [REG_DATA_W-1:0] wr_data = '0;
  int                    errors, pending;

  int unsigned cur_base;
  bit          gaps_on = 1;
  bit          hold_on = 0;
  int          quiet = 0;
  int          chars_sent = 0;

  always #10 clk = ~clk;

  text_to_integer_parser dut (.*);

  ttip_checker chk (.*);

  // receiver: per-transaction stall plus one long hold-off
  initial begin
    int w;
    bit held;
    bit took;
    held = 0;
    forever begin
      @(posedge clk);
      took = !rst && result_valid && !result_stall;
      @(negedge clk);
      if (hold_on && !held) begin
        held = 1;
        result_stall = 1;
        repeat (LONG_HOLD) @(negedge clk);
        result_stall = 0;
      end else if (took && gaps_on) begin
        w = $urandom_range(0, 5);
        if (w > 0) begin
          result_stall = 1;
          repeat (w) @(negedge clk);
          result_stall = 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall) || wr_en)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c, logic fin);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      char_valid = 0;
      repeat (gap) @(negedge clk);
    end
    char_data.char_code = c;
    char_data.last = fin;
    char_valid = 1;
    do @(posedge clk); while (char_stall);
    @(negedge clk);
    chars_sent++;
  endtask

  // zero_end: terminate with a zero byte instead of marking the final char
  task automatic send_bytes(logic [7:0] s [$], bit zero_end);
    foreach (s[i]) send_char(s[i], !zero_end && i == s.size() - 1);
    if (zero_end || s.size() == 0) send_char(8'd0, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(string s, bit zero_end);
    logic [7:0] q [$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q, zero_end);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int val);
    wr_index = idx;
    wr_data = val[REG_DATA_W-1:0];
    wr_en = 1;
    @(negedge clk);
    wr_en = 0;
  endtask

  task automatic configure(int base, int width, bit sgn, bit p2, bit sup, bit resc);
    char_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    write_reg(REG_BASE_SETTING, base);
    write_reg(REG_RESULT_WIDTH, width);
    write_reg(REG_SIGNED_RESULT, sgn);
    write_reg(REG_POW2_UNSIGNED, p2);
    write_reg(REG_SUPPRESS_OVF, sup);
    write_reg(REG_PREFIX_RESCAN, resc);
    cur_base = base;
  endtask

  function automatic logic [7:0] digit_char(int unsigned v, int unsigned b);
    if (v < 10) return 8'(48 + v);
    if (v < 36) return 8'(((b <= 36 && $urandom_range(0, 1)) ? 65 : 97) + v - 10);
    if (v < 62) return 8'(65 + v - 36);
    return (v == 62) ? CH_AT : CH_US;
  endfunction

  task automatic send_random_number();
    logic [7:0] q [$];
    int unsigned b, nd, k, pb;
    if ($urandom_range(0, 99) < 15) begin
      nd = $urandom_range(1, 6);
      repeat (nd) q.push_back(8'($urandom_range(1, 255)));
      send_bytes(q, 1'($urandom_range(0, 1)));
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(0, 5);
      q.push_back(k == 5 ? CH_SPACE : 8'(CH_TAB + k));
    end
    k = $urandom_range(0, 2);
    if (k == 1) q.push_back(CH_PLUS);
    if (k == 2) q.push_back(CH_MINUS);
    b = (cur_base >= 2 && cur_base <= 64) ? cur_base : 10;
    if (cur_base == 0) begin
      k = $urandom_range(0, 4);
      if (k == 1) begin
        q.push_back(8'd48); q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX); b = 16;
      end else if (k == 2) begin
        q.push_back(8'd48); q.push_back($urandom_range(0, 1) ? CH_LB : CH_UB); b = 2;
      end else if (k == 3) begin
        q.push_back(8'd48); b = 8;
      end else if (k == 4) begin
        pb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(2, 64);
        if (pb >= 10) q.push_back(8'(48 + pb / 10));
        q.push_back(8'(48 + pb % 10));
        q.push_back(CH_HASH);
        if (pb >= 2 && pb <= 64) b = pb;
        if ($urandom_range(0, 4) == 0) q.push_back(CH_MINUS);
      end
    end else if (b == 16 && $urandom_range(0, 2) == 0) begin
      q.push_back(8'd48); q.push_back(CH_LX);
    end
    nd = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 12);
    repeat (nd) q.push_back(digit_char($urandom_range(0, b - 1), b));
    if ($urandom_range(0, 4) == 0) q.push_back(8'($urandom_range(1, 255)));
    send_bytes(q, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 0;
    cur_base = 0;

    send_text("", 1);
    send_text("   -123", 0);
    send_text("0x", 0);
    send_text("0b", 1);
    send_text("0x1F", 0);
    send_text("0b101", 1);
    send_text("0777", 0);
    send_text("18446744073709551615", 0);
    send_text("99999999999999999999 ", 1);
    send_text("36#zZ", 0);
    send_text("64#@_Az", 0);
    send_text("12#", 0);
    send_text("+ ", 0);
    send_text("0", 0);
    send_text("12a", 0);
    send_bytes('{8'h35, 8'hC1}, 0);

    configure(10, WIDTH_8, 1, 0, 0, 0);
    send_text("-128", 0);
    send_text("-129", 0);
    send_text("127", 0);
    send_text("300", 1);
    configure(1, WIDTH_16, 0, 0, 1, 0);
    send_text("5", 0);
    configure(127, WIDTH_32, 1, 1, 0, 1);
    send_text("5", 0);
    configure(0, WIDTH_8, 1, 1, 0, 1);
    send_text("16# -ff", 0);
    send_text("2#x", 0);
    send_text("0xff", 0);

    for (int ph = 0; chars_sent < 620 || ph < 5; ph++) begin
      case (ph)
        0: configure(64, WIDTH_64, 1, 1, 0, 0);
        1: configure(2, WIDTH_16, 1, 0, 1, 0);
        2: configure(16, WIDTH_32, 1, 1, 0, 0);
        3: configure(0, WIDTH_64, 0, 0, 0, 1);
        4: configure(37, WIDTH_8, 0, 0, 0, 0);
        default: configure($urandom_range(0, 9) == 0 ? $urandom_range(0, 127) :
                           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 64)),
                           $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      gaps_on = (ph % 4 != 2);
      if (ph == 3) hold_on = 1;
      for (int s = 0; s < 4; s++) send_random_number();
    end

    char_valid = 0;
    gaps_on = 1;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

@@ text_to_integer_parser.f @@
sv/ttip_pkg.sv
sv/ttip_step.sv
sv/ttip_finish.sv
sv/text_to_integer_parser.sv
test/ttip_checker.sv
test/tb.sv
